### rtl/ptd_pkg.sv
// Package for the periodic task dispatcher: request and status codes,
// the task memory word and the controller/datapath command and status structs.
// Depends on nothing.
package ptd_pkg;

	localparam int REQ_W     = 3;
	localparam int ID_W      = 6;
	localparam int TIME_W    = 32;
	localparam int EXTRA_W   = 16;
	localparam int STATUS_W  = 2;
	localparam int PRESENT_W = 7;

	localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_RUN   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DONE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RESET = 3'd3;
	localparam logic [REQ_W-1:0] REQ_QUERY = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOIDX = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] duration;
		logic [TIME_W-1:0] overrun;
	} task_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [ID_W-1:0]      task_id;
		logic                 dispatch;
		logic [TIME_W-1:0]    exec_time;
		logic [TIME_W-1:0]    overrun_total;
		logic [TIME_W-1:0]    scan_gap;
		logic [PRESENT_W-1:0] tasks_present;
		logic                 last;
	} ptd_res_t;

	typedef struct packed {
		logic capture;
		logic rd;
		logic eval;
		logic commit;
	} ptd_cmd_t;

	typedef struct packed {
		logic out_free;
		logic more;
	} ptd_sts_t;

endpackage

### rtl/ptd_ctrl.sv
// Controller of the periodic task dispatcher: sequences capture, memory read,
// evaluation and commit of each transaction. Depends on ptd_pkg.
module ptd_ctrl import ptd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  ptd_sts_t sts,
	output ptd_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign s_tready = ready_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.capture = s_tvalid;
			ST_READ:   cmd.rd = 1'b1;
			ST_EVAL:   cmd.eval = 1'b1;
			ST_COMMIT: cmd.commit = sts.out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_READ;
						ready_q <= 1'b0;
					end
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (sts.out_free) begin
						if (sts.more) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

### rtl/ptd_dp.sv
// Datapath of the periodic task dispatcher: request registers, task memory,
// scan counter, evaluation stage and result register. Depends on ptd_pkg.
module ptd_dp import ptd_pkg::*; #(
	parameter int MAX_TASKS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ptd_cmd_t                  cmd,
	output ptd_sts_t                  sts,
	input  logic [REQ_W-1:0]          req_type,
	input  logic [ID_W-1:0]           task_index,
	input  logic [TIME_W-1:0]         time_now,
	input  logic [TIME_W-1:0]         interval_value,
	input  logic signed [EXTRA_W-1:0] extra_time,
	input  logic [TIME_W-1:0]         run_duration,
	input  logic                      m_ready,
	output logic                      m_valid,
	output ptd_res_t                  res
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	logic [REQ_W-1:0]   req_q;
	logic [ID_W-1:0]    idx_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  ival_q;
	logic [EXTRA_W-1:0] extra_q;
	logic [TIME_W-1:0]  dur_q;

	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  scan_q;
	logic [TIME_W-1:0] prev_q;
	logic [TIME_W-1:0] gap_q;

	task_word_t task_mem [MAX_TASKS];
	task_word_t rdata_q;

	logic [TIME_W-1:0] due_s2;
	logic [TIME_W-1:0] excess_s2;
	logic              ovr_ok_s2;
	logic              dur_ge_s2;

	ptd_res_t res_q;
	ptd_res_t res_nxt;
	logic     valid_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	task_word_t       wdata;
	logic             we;
	logic             disp;
	logic             idx_ok;
	logic [CNT_W-1:0] fill_nxt;
	logic [CNT_W-1:0] scan_nxt;
	logic             more;

	assign rd_addr  = (req_q == REQ_RUN) ? scan_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign idx_ok   = {1'b0, idx_q} < PRESENT_W'(fill_q);
	assign scan_nxt = CNT_W'(scan_q + 1'b1);

	always_comb begin
		we       = 1'b0;
		wr_addr  = rd_addr;
		wdata    = rdata_q;
		disp     = 1'b0;
		fill_nxt = fill_q;
		more     = 1'b0;
		res_nxt  = '0;
		res_nxt.status = ST_OK;
		res_nxt.scan_gap = gap_q;
		res_nxt.last = 1'b1;
		case (req_q)
			REQ_ADD: begin
				if (fill_q != CNT_W'(MAX_TASKS)) begin
					we = 1'b1;
					wr_addr = fill_q[IDX_W-1:0];
					wdata = '0;
					wdata.period = ival_q;
					fill_nxt = CNT_W'(fill_q + 1'b1);
					res_nxt.task_id = ID_W'(fill_q);
				end else begin
					res_nxt.status = ST_FULL;
				end
			end
			REQ_RUN: begin
				if (fill_q != '0) begin
					disp = (due_s2 <= now_q) && ovr_ok_s2;
					we = 1'b1;
					if (disp) begin
						wdata.start = now_q;
					end else if (dur_ge_s2) begin
						wdata.overrun = rdata_q.overrun + excess_s2;
					end
					res_nxt.task_id = ID_W'(scan_q);
					res_nxt.dispatch = disp;
					res_nxt.exec_time = rdata_q.duration;
					res_nxt.overrun_total = wdata.overrun;
					res_nxt.last = (scan_nxt == fill_q);
					more = (scan_nxt != fill_q);
				end
			end
			REQ_DONE, REQ_RESET, REQ_QUERY: begin
				res_nxt.task_id = idx_q;
				if (idx_ok) begin
					if (req_q == REQ_DONE) begin
						we = 1'b1;
						wdata.duration = dur_q;
					end else if (req_q == REQ_RESET) begin
						we = 1'b1;
						wdata.period = rdata_q.period + {{(TIME_W-EXTRA_W){extra_q[EXTRA_W-1]}}, extra_q};
						wdata.overrun = '0;
					end
					res_nxt.exec_time = wdata.duration;
					res_nxt.overrun_total = wdata.overrun;
				end else begin
					res_nxt.status = ST_NOIDX;
				end
			end
			default: begin
				res_nxt.status = ST_NOIDX;
			end
		endcase
		res_nxt.tasks_present = PRESENT_W'(fill_nxt);
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= task_mem[rd_addr];
		end
		if (cmd.commit && we) begin
			task_mem[wr_addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			idx_q   <= task_index;
			now_q   <= time_now;
			ival_q  <= interval_value;
			extra_q <= extra_time;
			dur_q   <= run_duration;
		end
		if (cmd.eval) begin
			due_s2    <= rdata_q.start + rdata_q.period;
			excess_s2 <= rdata_q.duration - rdata_q.period;
			ovr_ok_s2 <= (rdata_q.overrun >> 2) < rdata_q.period;
			dur_ge_s2 <= rdata_q.duration >= rdata_q.period;
		end
		if (cmd.commit) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			scan_q  <= '0;
			prev_q  <= '0;
			gap_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				scan_q <= '0;
				if (req_type == REQ_RUN) begin
					gap_q  <= time_now - prev_q;
					prev_q <= time_now;
				end
			end
			if (cmd.commit) begin
				fill_q  <= fill_nxt;
				scan_q  <= scan_nxt;
				valid_q <= 1'b1;
			end else if (m_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !valid_q || m_ready;
	assign sts.more     = more;
	assign m_valid      = valid_q;
	assign res          = res_q;

endmodule

### rtl/periodic_task_dispatcher_unit.sv
// Top level of the periodic task dispatcher: stream ports, field packing,
// controller and datapath. Depends on ptd_pkg, ptd_ctrl and ptd_dp.
//
// The block keeps a table of up to MAX_TASKS periodic tasks in a single-port
// memory. Every transaction is taken in the idle state and then runs through
// read, evaluate and commit of one task word per result, so an add, done,
// reset or query handles one task word and a run scan steps in turn through
// the words of all registered tasks (one word with no task registered), each
// by the memory read, evaluation and write-back sequence of that task.
// A finished result waits in an output register, and the next transaction is
// taken while it waits; a stalled output holds the sequence at commit.
module periodic_task_dispatcher_unit import ptd_pkg::*; #(
	parameter int MAX_TASKS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// task_index[5:0], time_now[37:6], interval_value[69:38], extra_time[85:70],
	// run_duration[117:86], zero[119:118]
	input  logic [119:0] s_tdata,
	// req_type[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// task_id[5:0], dispatch[6], exec_time[38:7], overrun_total[70:39],
	// scan_gap[102:71], tasks_present[109:103], zero[111:110]
	output logic [111:0] m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	ptd_cmd_t cmd;
	ptd_sts_t sts;
	ptd_res_t res;

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptd_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (s_tuser),
		.task_index     (s_tdata[5:0]),
		.time_now       (s_tdata[37:6]),
		.interval_value (s_tdata[69:38]),
		.extra_time     (s_tdata[85:70]),
		.run_duration   (s_tdata[117:86]),
		.m_ready        (m_tready),
		.m_valid        (m_tvalid),
		.res            (res)
	);

	assign m_tdata = {2'b00, res.tasks_present, res.scan_gap, res.overrun_total,
		res.exec_time, res.dispatch, res.task_id};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

endmodule
